>>> src/flow_min_interval_tracker_unit_macros.svh
// Assertion macros for the flow interval tracker.
`ifndef FLOW_MIN_INTERVAL_TRACKER_UNIT_MACROS_SVH
`define FLOW_MIN_INTERVAL_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FMIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FMIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/fmit_pkg.sv
// ----------------------------------------------------------------------------
// fmit_pkg
// Types and constants shared by the flow interval tracker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmit_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 64;
    localparam int TIME_W      = 40;
    localparam int GAP_W       = 32;

    localparam logic [GAP_W-1:0] GAP_NONE = {GAP_W{1'b1}};
    localparam logic [GAP_W-1:0] GAP_MAX  = {1'b0, {(GAP_W-1){1'b1}}};

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DROP   = 1'b1;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic              is_close;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic              in_table;  // scan index below fill count
        logic              at_end;    // scan index equals fill count
        logic              found;     // key already matched earlier in scan
    } ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

>>> src/fmit_cell.sv
// ----------------------------------------------------------------------------
// fmit_cell
// One table entry: compares the scanned key, updates its gap, appends a new
// flow, or takes its right neighbor's entry while a closed flow is removed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmit_cell
    import fmit_pkg::*;
(
    input  logic              clk,
    input  logic              sel,
    input  ctl_t              ctl,
    input  logic              load_right,
    input  logic [KEY_W-1:0]  right_key,
    input  logic [TIME_W-1:0] right_time,
    input  logic [GAP_W-1:0]  right_gap,
    output logic [KEY_W-1:0]  ent_key,
    output logic [TIME_W-1:0] ent_time,
    output logic [GAP_W-1:0]  ent_gap,
    output logic              hit,
    output logic [GAP_W-1:0]  hit_gap
);

    logic [KEY_W-1:0]  key_reg,  key_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [GAP_W-1:0]  gap_reg,  gap_next;
    logic [TIME_W-1:0] diff;
    logic [GAP_W-1:0]  sat;
    logic              match;

    assign match   = sel && ctl.in_table && !ctl.found && (key_reg == ctl.key);
    assign hit     = match;
    assign hit_gap = match ? gap_reg : '0;

    // wrapped gap, saturated to 31 bits
    assign diff = ctl.now - time_reg;
    assign sat  = (diff[TIME_W-1:GAP_W-1] != '0) ? GAP_MAX
                                                : {1'b0, diff[GAP_W-2:0]};

    always_comb
    begin
        key_next  = key_reg;
        time_next = time_reg;
        gap_next  = gap_reg;
        if (load_right)
        begin
            key_next  = right_key;
            time_next = right_time;
            gap_next  = right_gap;
        end
        else if (match && !ctl.is_close)
        begin
            time_next = ctl.now;
            if (gap_reg == GAP_NONE || sat < gap_reg)
                gap_next = sat;
        end
        else if (sel && ctl.at_end && !ctl.found && !ctl.is_close)
        begin
            key_next  = ctl.key;
            time_next = ctl.now;
            gap_next  = GAP_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        time_reg <= time_next;
        gap_reg  <= gap_next;
    end

    assign ent_key  = key_reg;
    assign ent_time = time_reg;
    assign ent_gap  = gap_reg;

endmodule

>>> src/flow_min_interval_tracker_unit.sv
// ----------------------------------------------------------------------------
// flow_min_interval_tracker_unit
// Per-flow smallest inter-arrival gap table with a scan across a cell row.
// ----------------------------------------------------------------------------
//  channel | handshake          | word fields
//  in      | in_valid/in_stall  | is_close, flow_id, now_ms
//  out     | out_valid/out_stall| kind, report_id, best_gap
//
//  Each word passes through the accept state, a scan that visits each cell in
//  turn, and a finish state; a new word is accepted only back in idle.
//  Reset clears the fill count and control; entry contents are not cleared.
//  A result waits in the output register while the next word is scanned;
//  the finish state holds if that register is still full and stalled.
`timescale 1ns / 1ps

module flow_min_interval_tracker_unit
    import fmit_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     is_close,
    input  logic [KEY_W-1:0]         flow_id,
    input  logic [TIME_W-1:0]        now_ms,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     kind,
    output logic [KEY_W-1:0]         report_id,
    output logic signed [GAP_W-1:0]  best_gap
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;
    logic              tok_close_reg;
    logic [KEY_W-1:0]  tok_key_reg;
    logic [TIME_W-1:0] tok_now_reg;
    logic [GAP_W-1:0]  gap_sv_reg, gap_sv_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_kind_reg, res_kind_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg;
    logic [KEY_W-1:0]  out_id_reg;
    logic [GAP_W-1:0]  out_gap_reg;

    ctl_t              ctl;
    logic              accept, last_step, hit, found_now, out_load;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [KEY_W-1:0]  key_arr  [TABLE_DEPTH];
    logic [TIME_W-1:0] time_arr [TABLE_DEPTH];
    logic [GAP_W-1:0]  gap_arr  [TABLE_DEPTH];
    logic [GAP_W-1:0]  hgap_arr [TABLE_DEPTH];
    logic [GAP_W-1:0]  hit_gap;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign last_step = (idx_reg == IDX_W'(TABLE_DEPTH - 1));

    assign ctl.is_close = tok_close_reg;
    assign ctl.key      = tok_key_reg;
    assign ctl.now      = tok_now_reg;
    assign ctl.in_table = (CNT_W'(idx_reg) < count_reg);
    assign ctl.at_end   = (CNT_W'(idx_reg) == count_reg);
    assign ctl.found    = found_reg;

    // cell row
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic sel_i, load_i;
        assign sel_i = (state_reg == ST_SCAN) && (idx_reg == IDX_W'(i));
        if (i < TABLE_DEPTH - 1)
        begin : g_mid
            assign load_i = (state_reg == ST_SCAN) && found_reg && tok_close_reg
                            && (idx_reg == IDX_W'(i + 1));
            fmit_cell u_cell (
                .clk(clk), .sel(sel_i), .ctl(ctl), .load_right(load_i),
                .right_key(key_arr[i+1]), .right_time(time_arr[i+1]),
                .right_gap(gap_arr[i+1]),
                .ent_key(key_arr[i]), .ent_time(time_arr[i]), .ent_gap(gap_arr[i]),
                .hit(hit_vec[i]), .hit_gap(hgap_arr[i])
            );
        end
        else
        begin : g_last
            assign load_i = 1'b0;
            fmit_cell u_cell (
                .clk(clk), .sel(sel_i), .ctl(ctl), .load_right(load_i),
                .right_key(key_arr[i]), .right_time(time_arr[i]),
                .right_gap(gap_arr[i]),
                .ent_key(key_arr[i]), .ent_time(time_arr[i]), .ent_gap(gap_arr[i]),
                .hit(hit_vec[i]), .hit_gap(hgap_arr[i])
            );
        end
    end

    // collect the active cell's match
    assign hit = |hit_vec;
    always_comb
    begin
        hit_gap = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            hit_gap = hit_gap | hgap_arr[i];
    end

    assign found_now = found_reg || hit;
    assign out_load  = (state_reg == ST_DONE) && res_valid_reg
                       && (!out_valid_reg || !out_stall);

    // control
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        gap_sv_next    = gap_sv_reg;
        res_valid_next = res_valid_reg;
        res_kind_next  = res_kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next     = ST_SCAN;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    res_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next  = 1'b1;
                    gap_sv_next = hit_gap;
                end
                if (last_step)
                begin
                    state_next = ST_DONE;
                    if (tok_close_reg && found_now)
                    begin
                        count_next     = count_reg - CNT_W'(1);
                        res_valid_next = 1'b1;
                        res_kind_next  = KIND_REPORT;
                    end
                    else if (!tok_close_reg && !found_now)
                    begin
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_valid_next = 1'b1;
                            res_kind_next  = KIND_DROP;
                        end
                        else
                            count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_DONE:
            begin
                if (!res_valid_reg || out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // token and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_close_reg <= is_close;
            tok_key_reg   <= flow_id;
            tok_now_reg   <= now_ms;
        end
        gap_sv_reg   <= gap_sv_next;
        res_kind_reg <= res_kind_next;
        if (out_load)
        begin
            out_kind_reg <= res_kind_reg;
            out_id_reg   <= tok_key_reg;
            out_gap_reg  <= (res_kind_reg == KIND_DROP) ? GAP_NONE : gap_sv_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign report_id = out_id_reg;
    assign best_gap  = signed'(out_gap_reg);

`include "flow_min_interval_tracker_unit_macros.svh"

    `FMIT_ASSERT_NEXT(a_accept_scan, accept, state_reg == ST_SCAN, "accept did not start scan")
    `FMIT_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "fill count overflow")
    `FMIT_ASSERT_NOW(a_out_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE), "result not from finish")

endmodule

>>> verif/flow_min_interval_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// flow_min_interval_tracker_unit_tb
// Self-checking bench: directed and random arrival and close words drive the
// tracker, a local table model predicts close reports and table-full drops,
// and a monitor compares every output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flow_min_interval_tracker_unit_tb;
    import fmit_pkg::*;

    typedef struct packed {
        logic              is_close;
        logic [KEY_W-1:0]  flow_id;
        logic [TIME_W-1:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] report_id;
        logic [GAP_W-1:0] best_gap;
    } out_word_t;

    localparam longint CYCLE_LIMIT = 3000000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    is_close;
    logic [KEY_W-1:0]        flow_id;
    logic [TIME_W-1:0]       now_ms;
    logic                    out_valid;
    logic                    out_stall;
    logic                    kind;
    logic [KEY_W-1:0]        report_id;
    logic signed [GAP_W-1:0] best_gap;

    flow_min_interval_tracker_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .is_close(is_close), .flow_id(flow_id), .now_ms(now_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .report_id(report_id), .best_gap(best_gap)
    );

    // flow table shadow
    logic [KEY_W-1:0]  flow_key_q[TABLE_DEPTH];
    logic [TIME_W-1:0] flow_time_q[TABLE_DEPTH];
    logic [GAP_W-1:0]  flow_gap_q[TABLE_DEPTH];
    int                flow_count;

    in_word_t  pending_words[$];
    out_word_t expected_reports[$];
    int        errors;
    int        phase;       // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    longint    cycle_cnt;
    logic [KEY_W-1:0] key_pool[16];

    // apply one accepted word to the shadow table
    function automatic void track_flow(in_word_t w);
        int slot;
        logic [TIME_W-1:0] delta;
        logic [GAP_W-1:0]  g;
        out_word_t r;
        slot = -1;
        for (int i = 0; i < flow_count; i++)
        begin
            if (slot < 0 && flow_key_q[i] == w.flow_id)
                slot = i;
        end
        if (w.is_close)
        begin
            if (slot < 0)
                return;
            r.kind      = KIND_REPORT;
            r.report_id = w.flow_id;
            r.best_gap  = flow_gap_q[slot];
            expected_reports.push_back(r);
            flow_count--;
            flow_key_q[slot]  = flow_key_q[flow_count];
            flow_time_q[slot] = flow_time_q[flow_count];
            flow_gap_q[slot]  = flow_gap_q[flow_count];
        end
        else if (slot < 0)
        begin
            if (flow_count >= TABLE_DEPTH)
            begin
                r.kind      = KIND_DROP;
                r.report_id = w.flow_id;
                r.best_gap  = GAP_NONE;
                expected_reports.push_back(r);
            end
            else
            begin
                flow_key_q[flow_count]  = w.flow_id;
                flow_time_q[flow_count] = w.now_ms;
                flow_gap_q[flow_count]  = GAP_NONE;
                flow_count++;
            end
        end
        else
        begin
            // gap wraps mod 2^40, then saturates to 31 bits
            delta = w.now_ms - flow_time_q[slot];
            g = (delta > TIME_W'(GAP_MAX)) ? GAP_MAX : GAP_W'(delta);
            flow_time_q[slot] = w.now_ms;
            if (flow_gap_q[slot] == GAP_NONE || g < flow_gap_q[slot])
                flow_gap_q[slot] = g;
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_word_t make_word(bit cl, logic [KEY_W-1:0] id,
                                           logic [TIME_W-1:0] t);
        in_word_t w;
        w.is_close = cl;
        w.flow_id  = id;
        w.now_ms   = t;
        return w;
    endfunction

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            is_close <= 1'b0;
            flow_id  <= '0;
            now_ms   <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                track_flow(make_word(is_close, flow_id, now_ms));
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() > 0 &&
                    !((phase == 1 && $urandom_range(99) < 80) ||
                      (phase == 3 && $urandom_range(99) < 32)))
                begin
                    in_word_t w;
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    is_close <= w.is_close;
                    flow_id  <= w.flow_id;
                    now_ms   <= w.now_ms;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (phase == 2 && $urandom_range(99) < 80) ||
                         (phase == 3 && $urandom_range(99) < 32);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("unexpected word: kind=%0d report_id=%h best_gap=%0d",
                       kind, report_id, best_gap);
                errors++;
            end
            else
            begin
                out_word_t e;
                e = expected_reports.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind: expected %0d actual %0d", e.kind, kind);
                    errors++;
                end
                if (report_id !== e.report_id)
                begin
                    $error("report_id: expected %h actual %h", e.report_id, report_id);
                    errors++;
                end
                if (best_gap !== e.best_gap)
                begin
                    $error("best_gap: expected %0d actual %0d",
                           $signed(e.best_gap), best_gap);
                    errors++;
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (3 * TABLE_DEPTH) @(posedge clk);
    endtask

    // random phase: mostly pooled keys so flows live long enough to report
    task automatic run_random(int n);
        logic [TIME_W-1:0] t;
        t = TIME_W'({$urandom, $urandom});
        for (int i = 0; i < n; i++)
        begin
            int sel;
            logic [KEY_W-1:0] id;
            sel = $urandom_range(99);
            id = (sel < 85) ? key_pool[$urandom_range(15)] : rand64();
            if ($urandom_range(9) == 0)
                t = TIME_W'({$urandom, $urandom});
            else
                t = t + $urandom_range(5000);
            pending_words.push_back(make_word($urandom_range(99) < 20, id, t));
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        cycle_cnt = 0;
        phase = 0;
        flow_count = 0;
        for (int i = 0; i < 16; i++)
            key_pool[i] = rand64();
        @(posedge rst_n);
        @(posedge clk);

        // directed: extremes, wrap, saturation, unknown close, single-arrival close
        pending_words.push_back(make_word(1'b1, 64'h1234, 40'd0));
        pending_words.push_back(make_word(1'b0, '1, '1));
        pending_words.push_back(make_word(1'b0, '1, 40'd5));
        pending_words.push_back(make_word(1'b0, '1, 40'd12));
        pending_words.push_back(make_word(1'b1, '1, '0));
        pending_words.push_back(make_word(1'b0, '0, '0));
        pending_words.push_back(make_word(1'b0, '0, 40'hFF_FFFF_FFFF));
        pending_words.push_back(make_word(1'b1, '0, '0));
        pending_words.push_back(make_word(1'b0, 64'hA5A5, 40'd100));
        pending_words.push_back(make_word(1'b1, 64'hA5A5, 40'd100));
        pending_words.push_back(make_word(1'b0, 64'h5A5A, 40'd10));
        pending_words.push_back(make_word(1'b0, 64'h5A5A, 40'd10));
        pending_words.push_back(make_word(1'b1, 64'h5A5A, 40'd0));
        wait_drained();

        // fill the table, overflow it, then empty it out of order
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
            pending_words.push_back(make_word(1'b0, 64'h100 + i, 40'(i)));
        for (int i = 0; i < TABLE_DEPTH; i++)
            pending_words.push_back(make_word(1'b0, 64'h100 + i, 40'(3 * i + 7)));
        for (int i = 0; i < TABLE_DEPTH; i++)
            pending_words.push_back(make_word(1'b1, 64'h100 + ((i * 37) % TABLE_DEPTH),
                                              40'd0));
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            phase = p;
            run_random(300);
        end
        phase = 0;
        run_random(250);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
